### rtl/brmq_pkg.sv
// Shared types and constants for the bucketed range minimum query unit.
package brmq_pkg;

    // Request codes
    localparam logic REQ_ASSIGN = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // Largest signed 32-bit value, the reset content of every entry
    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic               req_type;
        logic [11:0]        position;
        logic [11:0]        range_end;
        logic signed [31:0] new_value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] min_value;
        logic               bad_request;
    } t_rsp;

endpackage

### rtl/bucketed_range_min_query_unit.sv
// An assign divides its position by the bucket size, writes the entry and a lower bucket minimum,
// and rescans the bucket when the old value held the bucket minimum. A query in one bucket scans
// its elements; a wider one scans both partial buckets and the bucket minima between them.
// One request at a time; the single read port of each memory sets the scan rate.
// After reset a clearing pass fills both memories with the largest value;
// no request is taken until it ends.
module bucketed_range_min_query_unit #(
    parameter int NUM_ELEMENTS = 4096,
    parameter int BUCKET_SIZE  = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  brmq_pkg::t_req  i_in_req,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output brmq_pkg::t_rsp  o_out_rsp
);

    localparam int NB  = (NUM_ELEMENTS + BUCKET_SIZE - 1) / BUCKET_SIZE;
    localparam int EAW = $clog2(NUM_ELEMENTS);
    localparam int BKW = (NB > 1) ? $clog2(NB) : 1;
    localparam int PW  = ($clog2(NUM_ELEMENTS + 1) > 12) ? $clog2(NUM_ELEMENTS + 1) : 12;
    localparam int BW  = $clog2(BUCKET_SIZE + 1);
    localparam int SH  = PW;
    localparam logic [SH-1:0] RECIP = SH'((64'd1 << SH) / BUCKET_SIZE);
    localparam logic [PW-1:0] NE_W  = PW'(NUM_ELEMENTS);
    localparam logic [PW-1:0] B_W   = PW'(BUCKET_SIZE);
    localparam logic [PW-1:0] NB_W  = PW'(NB);

    // State codes
    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_DIV1    = 4'd2;
    localparam logic [3:0] ST_DIV2    = 4'd3;
    localparam logic [3:0] ST_CHECK   = 4'd4;
    localparam logic [3:0] ST_ASG_RD  = 4'd5;
    localparam logic [3:0] ST_ASG_UPD = 4'd6;
    localparam logic [3:0] ST_ESCAN   = 4'd7;
    localparam logic [3:0] ST_BSCAN   = 4'd8;
    localparam logic [3:0] ST_OUT     = 4'd9;

    // Scan phase codes
    localparam logic [1:0] PH_LAST   = 2'd0;
    localparam logic [1:0] PH_FIRST  = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;
    localparam logic [1:0] PH_RESCAN = 2'd3;

    logic [3:0]         r_state;
    logic [1:0]         r_phase;
    brmq_pkg::t_req     r_req;
    logic [PW-1:0]      r_left, r_right;
    logic [PW-1:0]      r_lb, r_rb, r_lstart, r_rstart;
    logic               r_div_sel;
    logic [PW+SH-1:0]   r_prod;
    logic [PW-1:0]      r_cur, r_lim;
    logic               r_rdv;
    logic signed [31:0] r_acc;
    logic signed [31:0] r_res_min;
    logic               r_res_bad;
    logic               r_out_valid;
    brmq_pkg::t_rsp     r_rsp;

    // Memories
    logic signed [31:0] elem_mem [NUM_ELEMENTS];
    logic signed [31:0] bmin_mem [NB];
    logic signed [31:0] r_erd, r_brd;

    logic               e_we, b_we;
    logic [EAW-1:0]     e_wa, e_ra;
    logic [BKW-1:0]     b_wa, b_ra;
    logic signed [31:0] e_wd, b_wd;

    // Request decode
    logic          in_acc;
    logic [PW-1:0] in_pos, in_end;
    logic          in_bad;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign in_pos     = PW'(i_in_req.position);
    assign in_end     = PW'(i_in_req.range_end);
    assign in_bad     = (in_pos >= NE_W) ||
                        ((i_in_req.req_type == brmq_pkg::REQ_QUERY) &&
                         ((in_end >= NE_W) || (in_pos > in_end)));

    // Divide by the bucket size: reciprocal estimate, then one correction
    logic [PW-1:0]    div_op, q0, rem0, div_q, div_start;
    logic [PW+BW-1:0] qb;
    logic             div_fix;

    assign div_op    = r_div_sel ? r_right : r_left;
    assign q0        = r_prod[PW+SH-1:SH];
    assign qb        = (PW+BW)'(q0) * (PW+BW)'(BUCKET_SIZE);
    assign rem0      = div_op - qb[PW-1:0];
    assign div_fix   = (rem0 >= B_W);
    assign div_q     = q0 + PW'(div_fix);
    assign div_start = div_op - (div_fix ? (rem0 - B_W) : rem0);

    // End of the left bucket, clipped to the array size
    logic [PW:0]   lend_sum;
    logic [PW-1:0] lend;

    assign lend_sum = {1'b0, r_lstart} + (PW+1)'(BUCKET_SIZE);
    assign lend     = (lend_sum > {1'b0, NE_W}) ? NE_W : lend_sum[PW-1:0];

    // Scan control
    logic scan_issue, scan_done;
    logic signed [31:0] scan_data;

    assign scan_issue = (r_cur != r_lim);
    assign scan_done  = !scan_issue && !r_rdv;
    assign scan_data  = (r_state == ST_BSCAN) ? r_brd : r_erd;

    // Memory port control
    always_comb begin
        e_we = 1'b0;
        e_wa = r_cur[EAW-1:0];
        e_wd = brmq_pkg::INT_MAX;
        e_ra = r_cur[EAW-1:0];
        b_we = 1'b0;
        b_wa = r_cur[BKW-1:0];
        b_wd = brmq_pkg::INT_MAX;
        b_ra = r_cur[BKW-1:0];
        unique case (r_state)
            ST_CLEAR: begin
                e_we = 1'b1;
                b_we = (r_cur < NB_W);
            end
            // hold the assigned entry and its bucket minimum on the read ports
            ST_CHECK, ST_ASG_RD: begin
                e_ra = r_left[EAW-1:0];
                b_ra = r_lb[BKW-1:0];
            end
            ST_ASG_UPD: begin
                e_we = 1'b1;
                e_wa = r_left[EAW-1:0];
                e_wd = r_req.new_value;
                b_wa = r_lb[BKW-1:0];
                b_wd = r_req.new_value;
                b_we = (r_req.new_value < r_brd);
            end
            ST_ESCAN: begin
                b_wa = r_lb[BKW-1:0];
                b_wd = r_acc;
                b_we = scan_done && (r_phase == PH_RESCAN);
            end
            default: begin
            end
        endcase
    end

    // Element memory
    always_ff @(posedge i_clk) begin
        if (e_we) begin
            elem_mem[e_wa] <= e_wd;
        end
        r_erd <= elem_mem[e_ra];
    end

    // Bucket minimum memory
    always_ff @(posedge i_clk) begin
        if (b_we) begin
            bmin_mem[b_wa] <= b_wd;
        end
        r_brd <= bmin_mem[b_ra];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cur       <= '0;
            r_rdv       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result beat once taken
            if (r_out_valid && !i_out_stall && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_cur <= r_cur + 1'b1;
                    if (r_cur == NE_W - 1'b1) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_acc) begin
                        r_req     <= i_in_req;
                        r_left    <= in_pos;
                        r_right   <= (i_in_req.req_type == brmq_pkg::REQ_QUERY) ? in_end : in_pos;
                        r_div_sel <= 1'b0;
                        r_res_min <= '0;
                        r_res_bad <= in_bad;
                        r_state   <= in_bad ? ST_OUT : ST_DIV1;
                    end
                end
                ST_DIV1: begin
                    r_prod  <= (PW+SH)'(div_op) * (PW+SH)'(RECIP);
                    r_state <= ST_DIV2;
                end
                ST_DIV2: begin
                    if (!r_div_sel) begin
                        r_lb     <= div_q;
                        r_lstart <= div_start;
                        if (r_req.req_type == brmq_pkg::REQ_QUERY) begin
                            r_div_sel <= 1'b1;
                            r_state   <= ST_DIV1;
                        end else begin
                            r_state <= ST_CHECK;
                        end
                    end else begin
                        r_rb     <= div_q;
                        r_rstart <= div_start;
                        r_state  <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    r_acc <= brmq_pkg::INT_MAX;
                    r_rdv <= 1'b0;
                    if (r_req.req_type == brmq_pkg::REQ_ASSIGN) begin
                        r_state <= ST_ASG_RD;
                    end else if (r_lb == r_rb) begin
                        r_cur   <= r_left;
                        r_lim   <= r_right + 1'b1;
                        r_phase <= PH_LAST;
                        r_state <= ST_ESCAN;
                    end else begin
                        r_cur   <= r_left;
                        r_lim   <= lend;
                        r_phase <= PH_FIRST;
                        r_state <= ST_ESCAN;
                    end
                end
                ST_ASG_RD: begin
                    r_state <= ST_ASG_UPD;
                end
                ST_ASG_UPD: begin
                    // rescan when the old value held the bucket minimum
                    if (!(r_req.new_value < r_brd) && (r_erd == r_brd)) begin
                        r_cur   <= r_lstart;
                        r_lim   <= lend;
                        r_phase <= PH_RESCAN;
                        r_state <= ST_ESCAN;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_ESCAN, ST_BSCAN: begin
                    if (scan_issue) begin
                        r_cur <= r_cur + 1'b1;
                    end
                    r_rdv <= scan_issue;
                    if (r_rdv && (scan_data < r_acc)) begin
                        r_acc <= scan_data;
                    end
                    if (scan_done) begin
                        if (r_state == ST_BSCAN) begin
                            r_res_min <= r_acc;
                            r_state   <= ST_OUT;
                        end else begin
                            case (r_phase)
                                PH_FIRST: begin
                                    r_cur   <= r_rstart;
                                    r_lim   <= r_right + 1'b1;
                                    r_phase <= PH_SECOND;
                                end
                                PH_SECOND: begin
                                    r_cur   <= r_lb + 1'b1;
                                    r_lim   <= r_rb;
                                    r_state <= ST_BSCAN;
                                end
                                PH_LAST: begin
                                    r_res_min <= r_acc;
                                    r_state   <= ST_OUT;
                                end
                                default: begin
                                    r_state <= ST_OUT;
                                end
                            endcase
                        end
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid       <= 1'b1;
                        r_rsp.min_value   <= r_res_min;
                        r_rsp.bad_request <= r_res_bad;
                        r_state           <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_rsp;

    // No result leaves while the memories are being cleared
    a_no_out_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_out_valid)
        else $error("result during clearing pass");

    // A scan cursor never runs past its limit
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_ESCAN) || (r_state == ST_BSCAN)) |-> (r_cur <= r_lim))
        else $error("scan cursor beyond limit");

    // A rejected request carries a zero minimum
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.bad_request) |-> (o_out_rsp.min_value == 32'sd0))
        else $error("rejected request with nonzero value");

endmodule

### verif/bucketed_range_min_query_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for the bucketed range minimum query unit: directed and random traffic, scoreboard.
module bucketed_range_min_query_unit_tb;

    localparam int NUM_ELEM    = 4096;
    localparam int BKT_SIZE    = 64;
    localparam int NUM_BKT     = (NUM_ELEM + BKT_SIZE - 1) / BKT_SIZE;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 2 * BKT_SIZE + NUM_BKT + 40;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_stall;
    brmq_pkg::t_req i_in_req;
    logic           o_out_valid;
    logic           i_out_stall;
    brmq_pkg::t_rsp o_out_rsp;

    bucketed_range_min_query_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    // Predictor state: element array and per-bucket minima
    logic signed [31:0] elem_mirror [NUM_ELEM];
    logic signed [31:0] bkt_min_mirror [NUM_BKT];
    brmq_pkg::t_rsp     rsp_expected_q [$];

    int  error_count;
    int  cycle_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  in_drain;

    // Clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Cycle counter with timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic signed [31:0] scan_min(int lo, int hi_excl,
                                                    logic signed [31:0] acc);
        logic signed [31:0] m;
        m = acc;
        for (int i = lo; i < hi_excl; i++)
            if (elem_mirror[i] < m) m = elem_mirror[i];
        return m;
    endfunction

    // Apply one request to the mirror and return the expected response
    function automatic brmq_pkg::t_rsp predict_min(brmq_pkg::t_req r);
        brmq_pkg::t_rsp     rsp;
        int                 lft, rgt, lb, rb, bk, bend;
        logic signed [31:0] old_val, acc;
        rsp = '0;
        lft = r.position;
        rgt = r.range_end;
        if (r.req_type == brmq_pkg::REQ_ASSIGN) begin
            if (lft >= NUM_ELEM) begin
                rsp.bad_request = 1'b1;
                return rsp;
            end
            bk = lft / BKT_SIZE;
            old_val = elem_mirror[lft];
            elem_mirror[lft] = r.new_value;
            bend = (bk + 1) * BKT_SIZE;
            if (bend > NUM_ELEM) bend = NUM_ELEM;
            if (r.new_value < bkt_min_mirror[bk])
                bkt_min_mirror[bk] = r.new_value;
            else if (old_val == bkt_min_mirror[bk])
                bkt_min_mirror[bk] = scan_min(bk * BKT_SIZE, bend, brmq_pkg::INT_MAX);
            return rsp;
        end
        if (lft >= NUM_ELEM || rgt >= NUM_ELEM || lft > rgt) begin
            rsp.bad_request = 1'b1;
            return rsp;
        end
        acc = brmq_pkg::INT_MAX;
        lb = lft / BKT_SIZE;
        rb = rgt / BKT_SIZE;
        if (lb == rb) begin
            acc = scan_min(lft, rgt + 1, acc);
        end else begin
            for (int b = lb + 1; b < rb; b++)
                if (bkt_min_mirror[b] < acc) acc = bkt_min_mirror[b];
            bend = (lb + 1) * BKT_SIZE;
            if (bend > NUM_ELEM) bend = NUM_ELEM;
            acc = scan_min(lft, bend, acc);
            acc = scan_min(rb * BKT_SIZE, rgt + 1, acc);
        end
        rsp.min_value = acc;
        return rsp;
    endfunction

    // Receiver: random stall and response check
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (rsp_expected_q.size() == 0) begin
                    $display("%0t: unexpected beat, actual min=%0d bad=%0b", $time,
                             o_out_rsp.min_value, o_out_rsp.bad_request);
                    error_count++;
                end else begin
                    brmq_pkg::t_rsp exp_rsp;
                    exp_rsp = rsp_expected_q.pop_front();
                    if (exp_rsp.min_value !== o_out_rsp.min_value) begin
                        $display("%0t: min_value expected %0d actual %0d", $time,
                                 exp_rsp.min_value, o_out_rsp.min_value);
                        error_count++;
                    end
                    if (exp_rsp.bad_request !== o_out_rsp.bad_request) begin
                        $display("%0t: bad_request expected %0b actual %0b", $time,
                                 exp_rsp.bad_request, o_out_rsp.bad_request);
                        error_count++;
                    end
                end
            end
        end
        i_out_stall <= (!in_drain && $urandom_range(99) < recv_stall_pct);
    end

    // Send one beat, honoring the idle rate, and wait for acceptance; valid stays up
    // until the next beat or an idle cycle replaces it
    task automatic send_req(brmq_pkg::t_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        rsp_expected_q.push_back(predict_min(r));
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_empty();
        i_in_valid <= 1'b0;
        in_drain = 1'b1;
        while (rsp_expected_q.size() != 0) @(posedge i_clk);
        in_drain = 1'b0;
    endtask

    function automatic brmq_pkg::t_req make_req(logic kind, int pos, int rend, int val);
        brmq_pkg::t_req r;
        r.req_type  = kind;
        r.position  = 12'(pos);
        r.range_end = 12'(rend);
        r.new_value = val;
        return r;
    endfunction

    // Random position biased to bucket edges and array ends
    function automatic int rand_pos();
        case ($urandom_range(5))
            0: return $urandom_range(7);
            1: return NUM_ELEM - 1 - $urandom_range(7);
            2: return $urandom_range(NUM_BKT - 1) * BKT_SIZE + $urandom_range(1);
            3: return $urandom_range(NUM_BKT - 1) * BKT_SIZE + BKT_SIZE - 1
                      - $urandom_range(1);
            default: return $urandom_range(NUM_ELEM - 1);
        endcase
    endfunction

    function automatic int rand_val();
        case ($urandom_range(4))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $urandom_range(20) - 10;
            default: return $urandom();
        endcase
    endfunction

    function automatic brmq_pkg::t_req rand_req();
        int a, b, t;
        a = rand_pos();
        case ($urandom_range(9))
            0: b = a + $urandom_range(3);
            1: b = a + $urandom_range(BKT_SIZE * 2);
            2: b = $urandom_range(NUM_ELEM - 1);
            default: b = a + $urandom_range(BKT_SIZE * 4);
        endcase
        if (b > NUM_ELEM - 1) b = NUM_ELEM - 1;
        if ($urandom_range(19) == 0) begin
            t = a; a = b; b = t;
        end
        return make_req(1'($urandom_range(1)), a, b, rand_val());
    endfunction

    // Directed: field extremes, both request kinds, rejected queries, bucket rescans
    task automatic test_directed();
        send_req(make_req(brmq_pkg::REQ_QUERY, 0, NUM_ELEM - 1, 0));
        send_req(make_req(brmq_pkg::REQ_ASSIGN, 0, 12'hFFF, 32'sh8000_0000));
        send_req(make_req(brmq_pkg::REQ_ASSIGN, NUM_ELEM - 1, 0, 32'sh7FFF_FFFF));
        send_req(make_req(brmq_pkg::REQ_ASSIGN, 70, 0, -5));
        send_req(make_req(brmq_pkg::REQ_ASSIGN, 100, 0, 3));
        send_req(make_req(brmq_pkg::REQ_QUERY, 64, 127, 32'hFFFF_FFFF));
        send_req(make_req(brmq_pkg::REQ_ASSIGN, 70, 0, 10));
        send_req(make_req(brmq_pkg::REQ_QUERY, 64, 127, 0));
        send_req(make_req(brmq_pkg::REQ_QUERY, 1, NUM_ELEM - 1, 0));
        send_req(make_req(brmq_pkg::REQ_QUERY, 0, 0, 0));
        send_req(make_req(brmq_pkg::REQ_QUERY, NUM_ELEM - 1, NUM_ELEM - 1, 0));
        send_req(make_req(brmq_pkg::REQ_QUERY, 5, 4, 0));
        send_req(make_req(brmq_pkg::REQ_QUERY, NUM_ELEM - 1, 0, 0));
        send_req(make_req(brmq_pkg::REQ_ASSIGN, 0, 0, 32'sh7FFF_FFFF));
        send_req(make_req(brmq_pkg::REQ_QUERY, 0, 63, 0));
        send_req(make_req(brmq_pkg::REQ_QUERY, 63, 64, 0));
        send_req(make_req(brmq_pkg::REQ_ASSIGN, 2047, 2048, -1));
        send_req(make_req(brmq_pkg::REQ_QUERY, 2000, 2100, 0));
        send_req(make_req(brmq_pkg::REQ_QUERY, 2048, 2048, 0));
        wait_empty();
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) send_req(rand_req());
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Pause sender until every response is back, then resume
    task automatic test_pause_drain();
        recv_stall_pct = 50;
        for (int i = 0; i < 10; i++) send_req(rand_req());
        wait_empty();
        send_req(make_req(brmq_pkg::REQ_QUERY, 0, NUM_ELEM - 1, 0));
        recv_stall_pct = 0;
    endtask

    initial begin
        error_count    = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        in_drain       = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_req       = '0;
        i_out_stall    = 1'b0;
        for (int i = 0; i < NUM_ELEM; i++) elem_mirror[i] = brmq_pkg::INT_MAX;
        for (int i = 0; i < NUM_BKT; i++) bkt_min_mirror[i] = brmq_pkg::INT_MAX;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(500, 0, 0);
        test_random(250, 88, 0);
        test_random(250, 0, 88);
        test_pause_drain();
        test_random(300, 37, 37);
        test_random(100, 0, 0);

        wait_empty();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
